// File: hdl/scag_pkg.sv
package scag_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned CountW = 24;
  localparam int unsigned LineW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SOURCE_BASE       = 3'd0,
    CFG_DEST_BASE         = 3'd1,
    CFG_TOTAL_BYTES       = 3'd2,
    CFG_SOURCE_LINE_WIDTH = 3'd3,
    CFG_SOURCE_LINE_GAP   = 3'd4,
    CFG_DEST_LINE_WIDTH   = 3'd5,
    CFG_DEST_LINE_GAP     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [AddrW-1:0]  source_base;
    logic [AddrW-1:0]  dest_base;
    logic [CountW-1:0] total_bytes;
    logic [LineW-1:0]  source_line_width;
    logic [LineW-1:0]  source_line_gap;
    logic [LineW-1:0]  dest_line_width;
    logic [LineW-1:0]  dest_line_gap;
  } cfg_t;

  typedef struct packed {
    logic             begin_transfer;
    logic [ByteW-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [AddrW-1:0] read_address;
    logic [AddrW-1:0] write_address;
    logic [ByteW-1:0] write_byte;
    logic             final_byte;
    logic             overrun;
  } result_t;

  // front to back handshake
  typedef struct packed {
    logic  valid;
    item_t item;
  } word_t;

  function automatic logic [LineW-1:0] eff_width(input logic [LineW-1:0] w);
    eff_width = (w == '0) ? LineW'(1) : w;
  endfunction

endpackage

// File: hdl/scag_front.sv
module scag_front #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  scag_pkg::item_t in_item_i,
  output scag_pkg::word_t word_o,
  input  logic          word_ready_i
);
  import scag_pkg::*;

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [IdxW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop, full;

  assign full       = (count_q == CntW'(QUEUE_DEPTH));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign pop        = word_o.valid && word_ready_i;

  assign word_o.valid = (count_q != '0);
  assign word_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + IdxW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + IdxW'(1);
    end
    count_d = count_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count missed a push");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");
`endif

endmodule

// File: hdl/scag_back.sv
module scag_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scag_pkg::cfg_t    cfg_i,
  input  scag_pkg::word_t   word_i,
  output logic              word_ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output scag_pkg::result_t result_o
);
  import scag_pkg::*;

  logic [AddrW-1:0]  src_ptr_q, src_ptr_d;
  logic [AddrW-1:0]  dst_ptr_q, dst_ptr_d;
  logic [LineW-1:0]  src_left_q, src_left_d;
  logic [LineW-1:0]  dst_left_q, dst_left_d;
  logic [CountW-1:0] bytes_left_q, bytes_left_d;
  logic              out_valid_q, out_valid_d;
  result_t           result_q, result_d;

  logic [AddrW-1:0]  src_cur, dst_cur;
  logic [LineW-1:0]  src_left_cur, dst_left_cur;
  logic [CountW-1:0] bytes_cur;
  logic [LineW:0]    src_step, dst_step;
  logic              take;

  assign word_ready_o = !out_valid_q || !out_stall_i;
  assign take         = word_i.valid && word_ready_o;

  always_comb begin
    if (word_i.item.begin_transfer) begin
      src_cur      = cfg_i.source_base;
      dst_cur      = cfg_i.dest_base;
      src_left_cur = eff_width(cfg_i.source_line_width);
      dst_left_cur = eff_width(cfg_i.dest_line_width);
      bytes_cur    = cfg_i.total_bytes;
    end else begin
      src_cur      = src_ptr_q;
      dst_cur      = dst_ptr_q;
      src_left_cur = src_left_q;
      dst_left_cur = dst_left_q;
      bytes_cur    = bytes_left_q;
    end

    src_step = (src_left_cur <= LineW'(1)) ?
               ({1'b0, cfg_i.source_line_gap} + (LineW+1)'(1)) : (LineW+1)'(1);
    dst_step = (dst_left_cur <= LineW'(1)) ?
               ({1'b0, cfg_i.dest_line_gap} + (LineW+1)'(1)) : (LineW+1)'(1);

    src_ptr_d    = src_ptr_q;
    dst_ptr_d    = dst_ptr_q;
    src_left_d   = src_left_q;
    dst_left_d   = dst_left_q;
    bytes_left_d = bytes_left_q;
    result_d     = result_q;
    out_valid_d  = out_valid_q && out_stall_i;

    if (take) begin
      out_valid_d = 1'b1;
      src_ptr_d    = src_cur;
      dst_ptr_d    = dst_cur;
      src_left_d   = src_left_cur;
      dst_left_d   = dst_left_cur;
      bytes_left_d = bytes_cur;
      if (bytes_cur == '0) begin
        result_d         = '0;
        result_d.overrun = 1'b1;
      end else begin
        result_d.read_address  = src_cur;
        result_d.write_address = dst_cur;
        result_d.write_byte    = word_i.item.data_byte;
        result_d.final_byte    = (bytes_cur == CountW'(1));
        result_d.overrun       = 1'b0;
        bytes_left_d = bytes_cur - CountW'(1);
        src_ptr_d    = src_cur + AddrW'(src_step);
        dst_ptr_d    = dst_cur + AddrW'(dst_step);
        src_left_d   = (src_left_cur <= LineW'(1)) ?
                       eff_width(cfg_i.source_line_width) : src_left_cur - LineW'(1);
        dst_left_d   = (dst_left_cur <= LineW'(1)) ?
                       eff_width(cfg_i.dest_line_width) : dst_left_cur - LineW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_ptr_q    <= '0;
      dst_ptr_q    <= '0;
      src_left_q   <= '0;
      dst_left_q   <= '0;
      bytes_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      src_ptr_q    <= src_ptr_d;
      dst_ptr_q    <= dst_ptr_d;
      src_left_q   <= src_left_d;
      dst_left_q   <= dst_left_d;
      bytes_left_q <= bytes_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

`ifndef NO_ASSERTIONS
  a_overrun_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.overrun) |->
      (result_q.read_address == '0 && result_q.write_address == '0 &&
       result_q.final_byte == 1'b0 && result_q.write_byte == '0))
    else $error("overrun word carries data");
  a_final_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && result_d.final_byte && !result_d.overrun) |=> bytes_left_q == '0)
    else $error("count not empty after final byte");
  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(bytes_left_q))
    else $error("state moved while output held");
`endif

endmodule

// File: hdl/strided_copy_address_generator.sv
// Strided copy address generator.
// Input channel: in_valid_i / in_stall_o with begin_transfer_i and data_byte_i,
// one source byte per word in copy order; begin_transfer_i reloads the
// pointers and counters from the registers before that byte is handled.
// Output channel: out_valid_o / out_stall_i with read_address_o,
// write_address_o, write_byte_o, final_byte_o and overrun_o, one word out
// for every word in, in order. A word after the transfer has run out gives
// overrun_o high with zero addresses and byte.
// The user must write registers through cfg_we_i / cfg_index_i / cfg_data_i
// only with no transfer in flight (not enforced); unused indexes are ignored.
// An accepted byte is held in the queue, then registered by the back end, whose
// single address update sets throughput: one byte per cycle unless stalled.
// A QUEUE_DEPTH-word queue between front and back absorbs output stalls;
// in_stall_o rises only once it is full, and a stalled output word holds.
// Reset empties the queue and output, clears pointers and counters and
// loads the register reset values (line widths 1, all else 0).
module strided_copy_address_generator #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scag_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [scag_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            begin_transfer_i,
  input  logic [scag_pkg::ByteW-1:0]      data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [scag_pkg::AddrW-1:0]      read_address_o,
  output logic [scag_pkg::AddrW-1:0]      write_address_o,
  output logic [scag_pkg::ByteW-1:0]      write_byte_o,
  output logic                            final_byte_o,
  output logic                            overrun_o
);
  import scag_pkg::*;

  cfg_t    cfg_q;
  item_t   in_item;
  word_t   word;
  logic    word_ready;
  result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_base       <= '0;
      cfg_q.dest_base         <= '0;
      cfg_q.total_bytes       <= '0;
      cfg_q.source_line_width <= LineW'(1);
      cfg_q.source_line_gap   <= '0;
      cfg_q.dest_line_width   <= LineW'(1);
      cfg_q.dest_line_gap     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SOURCE_BASE:       cfg_q.source_base       <= cfg_data_i[AddrW-1:0];
        CFG_DEST_BASE:         cfg_q.dest_base         <= cfg_data_i[AddrW-1:0];
        CFG_TOTAL_BYTES:       cfg_q.total_bytes       <= cfg_data_i[CountW-1:0];
        CFG_SOURCE_LINE_WIDTH: cfg_q.source_line_width <= cfg_data_i[LineW-1:0];
        CFG_SOURCE_LINE_GAP:   cfg_q.source_line_gap   <= cfg_data_i[LineW-1:0];
        CFG_DEST_LINE_WIDTH:   cfg_q.dest_line_width   <= cfg_data_i[LineW-1:0];
        CFG_DEST_LINE_GAP:     cfg_q.dest_line_gap     <= cfg_data_i[LineW-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.begin_transfer = begin_transfer_i;
  assign in_item.data_byte      = data_byte_i;

  scag_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .word_o      (word),
    .word_ready_i(word_ready)
  );

  scag_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .word_i      (word),
    .word_ready_o(word_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign read_address_o  = result.read_address;
  assign write_address_o = result.write_address;
  assign write_byte_o    = result.write_byte;
  assign final_byte_o    = result.final_byte;
  assign overrun_o       = result.overrun;

endmodule
